/* rtl/core/ervg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ervg_pkg
// Types, operand selectors and the sine table shared by the ellipsoid ring
// vertex generator.
// ----------------------------------------------------------------------------
package ervg_pkg;

  typedef struct packed {
    logic               mode;
    logic [1:0]         point_slot;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [3:0]         ring;
  } req_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [3:0]         column;
    logic               last;
    logic               status;
  } res_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RING = 1'b1;

  // Multiplier operand and write-back selectors, in issue order.
  localparam logic [2:0] SEL_A  = 3'd0;
  localparam logic [2:0] SEL_B  = 3'd1;
  localparam logic [2:0] SEL_C  = 3'd2;
  localparam logic [2:0] SEL_X  = 3'd3;
  localparam logic [2:0] SEL_Y  = 3'd4;
  localparam logic [2:0] SEL_SQ = 3'd5;

  // One iteration per bit pair of the 66-bit sum of squares.
  localparam int ROOT_STEPS = 33;
  localparam logic [5:0] ROOT_LAST = 6'(ROOT_STEPS - 1);

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       clr;
    logic       diff;
    logic       mul;
    logic       wb;
    logic [2:0] sel;
    logic       root;
    logic       store_r;
    logic       emit;
    logic       emit_inc;
    logic       last;
    logic [1:0] axis;
    logic [1:0] rsel;
  } ctl_t;

  localparam logic [16:0] QSINE [17] = '{
    17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25080, 17'd30893, 17'd36410,
    17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798, 17'd60547,
    17'd62714, 17'd64277, 17'd65220, 17'd65536
  };

  // Magnitude of sin for a phase in 1/64 turn; the sign is bit 5 of the phase.
  function automatic logic [16:0] sine_mag(input logic [5:0] p);
    logic [4:0] idx;
    idx = p[4] ? 5'(5'd16 - {1'b0, p[3:0]}) : {1'b0, p[3:0]};
    return QSINE[idx];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ellipsoid_ring_vertex_generator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ellipsoid_ring_vertex_generator_core
// Stores an ellipsoid centre and three axis endpoints and, on a ring request,
// emits the vertices of one latitude ring in signed Q16.16.
// ----------------------------------------------------------------------------
//  Channel   Signals                  Transfer
//  request   start, busy, request     taken at an edge with start high, busy low
//  result    done, result             one cycle per result, cannot be held off
//
// A load request leaves busy low, so loads may follow one another on every
// cycle. For a ring request with all four points loaded, each radius needs
// 33 square root iterations of the one-bit-a-cycle root unit, and every
// coordinate goes through the single shared multiplier followed by a
// write-back cycle. An incomplete ring request gives its one result through
// the S_INC state, which registers the result and done.
// Reset clears the controller and the loaded mask; stored points are not
// cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module ellipsoid_ring_vertex_generator_core import ervg_pkg::*; #(
  parameter int LATITUDES  = 8,
  parameter int LONGITUDES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t request,
  output logic      done,
  output res_t      result
);

  localparam int CW = $clog2(LONGITUDES);

  ctl_t          ctl;
  logic          mask_full;
  logic [CW-1:0] col;

  // The controller sequences radius set-up and the column loop; all
  // arithmetic and storage lives in the datapath.
  ervg_ctrl #(.LONGITUDES(LONGITUDES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (request.mode),
    .mask_full (mask_full),
    .busy      (busy),
    .done      (done),
    .ctl       (ctl),
    .col       (col)
  );

  ervg_dp #(.LATITUDES(LATITUDES), .LONGITUDES(LONGITUDES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .col       (col),
    .request   (request),
    .mask_full (mask_full),
    .result    (result)
  );

endmodule
`default_nettype wire

/* rtl/core/ervg_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ervg_dp
// Point store, shared multiplier, bit-serial square root and vertex
// write-back, driven by commands from the controller.
// ----------------------------------------------------------------------------
module ervg_dp import ervg_pkg::*; #(
  parameter int LATITUDES  = 8,
  parameter int LONGITUDES = 16,
  localparam int CW = $clog2(LONGITUDES),
  localparam int RW = $clog2(LATITUDES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ctl_t          ctl,
  input  wire logic [CW-1:0] col,
  input  wire req_t          request,
  output logic               mask_full,
  output res_t               result
);

  logic signed [31:0] x_mem [4];
  logic signed [31:0] y_mem [4];
  logic signed [31:0] z_mem [4];
  logic [3:0]   mask;
  logic [3:0]   ring_reg;
  logic [32:0]  diff;
  logic [67:0]  prod;
  logic [65:0]  acc;
  logic [35:0]  rem;
  logic [33:0]  root;
  logic [33:0]  rad [3];
  logic [33:0]  ma;
  logic [33:0]  mb;
  logic signed [31:0] x_reg, y_reg, z_reg;

  logic [5:0] phi_tab [LATITUDES+1];
  logic [5:0] th_tab  [LONGITUDES];

  for (genvar g = 0; g <= LATITUDES; g++) begin : g_phi
    assign phi_tab[g] = 6'((g * 32 + LATITUDES / 2) / LATITUDES + 48);
  end
  for (genvar g = 0; g < LONGITUDES; g++) begin : g_th
    assign th_tab[g] = 6'((g * 64 + LONGITUDES / 2) / LONGITUDES);
  end

  logic [5:0]  ring_c;
  logic [5:0]  sphi_p, cphi_p, sth_p, cth_p;
  logic [16:0] sphi_m, cphi_m, sth_m, cth_m;
  logic signed [32:0] a_pt, b_pt;
  logic signed [32:0] d_raw;
  logic [33:0] op_a, op_b;
  logic [67:0] rnd;
  logic [33:0] mag;
  logic        neg;
  logic signed [31:0] base;
  logic signed [35:0] off, sum;
  logic signed [31:0] sat;
  logic [37:0] rem_sh, trial;

  always_comb begin
    ring_c = ({2'b00, ring_reg} > 6'(LATITUDES)) ? 6'(LATITUDES) : {2'b00, ring_reg};
    sphi_p = phi_tab[ring_c[RW-1:0]];
    cphi_p = 6'(sphi_p + 6'd16);
    sth_p  = th_tab[col];
    cth_p  = 6'(sth_p + 6'd16);
    sphi_m = sine_mag(sphi_p);
    cphi_m = sine_mag(cphi_p);
    sth_m  = sine_mag(sth_p);
    cth_m  = sine_mag(cth_p);
  end

  always_comb begin
    case (ctl.axis)
      2'd0:    begin a_pt = 33'(x_mem[ctl.rsel + 2'd1]); b_pt = 33'(x_mem[0]); end
      2'd1:    begin a_pt = 33'(y_mem[ctl.rsel + 2'd1]); b_pt = 33'(y_mem[0]); end
      default: begin a_pt = 33'(z_mem[ctl.rsel + 2'd1]); b_pt = 33'(z_mem[0]); end
    endcase
    d_raw = a_pt - b_pt;
  end

  always_comb begin
    case (ctl.sel)
      SEL_A:   begin op_a = rad[0]; op_b = 34'(cphi_m); end
      SEL_B:   begin op_a = rad[1]; op_b = 34'(cphi_m); end
      SEL_C:   begin op_a = rad[2]; op_b = 34'(sphi_m); end
      SEL_X:   begin op_a = ma;     op_b = 34'(cth_m);  end
      SEL_Y:   begin op_a = mb;     op_b = 34'(sth_m);  end
      default: begin op_a = 34'(diff); op_b = 34'(diff); end
    endcase
  end

  // Rounded scaling of the registered product and the saturating add.
  always_comb begin
    rnd = prod + 68'd32768;
    mag = rnd[49:16];
    case (ctl.sel)
      SEL_X:   begin neg = cphi_p[5] ^ cth_p[5]; base = x_mem[0]; end
      SEL_Y:   begin neg = cphi_p[5] ^ sth_p[5]; base = y_mem[0]; end
      default: begin neg = sphi_p[5];            base = z_mem[0]; end
    endcase
    off = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum = 36'(base) + off;
    if (sum > 36'sh07FFFFFFF)       sat = 32'sh7FFFFFFF;
    else if (sum < -36'sh080000000) sat = 32'sh80000000;
    else                            sat = sum[31:0];
  end

  always_comb begin
    rem_sh = {rem, acc[65:64]};
    trial  = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 4'd0;
    end else if (ctl.load) begin
      mask <= mask | (4'd1 << request.point_slot);
    end
  end

  assign mask_full = &mask;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_mem[request.point_slot] <= request.point_x;
      y_mem[request.point_slot] <= request.point_y;
      z_mem[request.point_slot] <= request.point_z;
    end
    if (ctl.capture) ring_reg <= request.ring;
    if (ctl.diff) diff <= d_raw[32] ? 33'(-d_raw) : 33'(d_raw);
    if (ctl.mul) prod <= op_a * op_b;
    if (ctl.clr) begin
      acc  <= '0;
      rem  <= '0;
      root <= '0;
    end else if (ctl.root) begin
      acc <= {acc[63:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= 36'(rem_sh - trial);
        root <= {root[32:0], 1'b1};
      end else begin
        rem  <= 36'(rem_sh);
        root <= {root[32:0], 1'b0};
      end
    end else if (ctl.wb && ctl.sel == SEL_SQ) begin
      acc <= acc + 66'(prod);
    end
    if (ctl.store_r) rad[ctl.rsel] <= root;
    if (ctl.wb) begin
      case (ctl.sel)
        SEL_A:   ma <= mag;
        SEL_B:   mb <= mag;
        SEL_C:   z_reg <= sat;
        SEL_X:   x_reg <= sat;
        SEL_Y:   y_reg <= sat;
        default: ;
      endcase
    end
    if (ctl.emit) begin
      result <= '{vertex_x: x_reg, vertex_y: y_reg, vertex_z: z_reg,
                  column: 4'(col), last: ctl.last, status: 1'b0};
    end else if (ctl.emit_inc) begin
      result <= '{vertex_x: '0, vertex_y: '0, vertex_z: '0,
                  column: 4'd0, last: 1'b1, status: 1'b1};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ervg_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ervg_ctrl
// Sequencer: request acceptance, radius set-up, square root iterations and the column loop.
// ----------------------------------------------------------------------------
module ervg_ctrl import ervg_pkg::*; #(
  parameter int LONGITUDES = 16,
  localparam int CW = $clog2(LONGITUDES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          mode,
  input  wire logic          mask_full,
  output logic               busy,
  output logic               done,
  output ctl_t               ctl,
  output logic [CW-1:0]      col
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_ROOT = 4'd5;
  localparam logic [3:0] S_STR  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;
  localparam logic [3:0] S_INC  = 4'd10;

  logic [3:0]    state, state_next;
  logic [1:0]    axis, axis_next;
  logic [1:0]    rsel, rsel_next;
  logic [5:0]    step, step_next;
  logic [2:0]    seq, seq_next;
  logic [CW-1:0] col_next;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    rsel_next  = rsel;
    step_next  = step;
    seq_next   = seq;
    col_next   = col;
    ctl        = '0;
    ctl.axis   = axis;
    ctl.rsel   = rsel;
    ctl.sel    = seq;
    ctl.last   = (col == CW'(LONGITUDES - 1));
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          if (mode == MODE_LOAD) begin
            ctl.load = 1'b1;
          end else if (mask_full) begin
            rsel_next  = 2'd0;
            state_next = S_CLR;
          end else begin
            state_next = S_INC;
          end
        end
      end
      S_CLR: begin
        ctl.clr    = 1'b1;
        axis_next  = 2'd0;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        ctl.diff   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        ctl.mul    = 1'b1;
        ctl.sel    = SEL_SQ;
        state_next = S_ACC;
      end
      S_ACC: begin
        ctl.wb  = 1'b1;
        ctl.sel = SEL_SQ;
        if (axis == 2'd2) begin
          step_next  = 6'd0;
          state_next = S_ROOT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_DIFF;
        end
      end
      S_ROOT: begin
        ctl.root  = 1'b1;
        step_next = step + 6'd1;
        if (step == ROOT_LAST) state_next = S_STR;
      end
      S_STR: begin
        ctl.store_r = 1'b1;
        if (rsel == 2'd2) begin
          seq_next   = SEL_A;
          col_next   = '0;
          state_next = S_MUL;
        end else begin
          rsel_next  = rsel + 2'd1;
          state_next = S_CLR;
        end
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        ctl.wb = 1'b1;
        if (seq == SEL_Y) begin
          state_next = S_EMIT;
        end else begin
          seq_next   = seq + 3'd1;
          state_next = S_MUL;
        end
      end
      S_EMIT: begin
        ctl.emit   = 1'b1;
        seq_next   = SEL_X;
        col_next   = col + CW'(1);
        state_next = ctl.last ? S_IDLE : S_MUL;
      end
      S_INC: begin
        ctl.emit_inc = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.emit | ctl.emit_inc;
    end
    axis <= axis_next;
    rsel <= rsel_next;
    step <= step_next;
    seq  <= seq_next;
    col  <= col_next;
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

/* rtl/core/ervg_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ervg_checker
// Port-level checks on the ring vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
module ervg_checker import ervg_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire req_t request,
  input wire logic done,
  input wire res_t result
);

  // An incomplete status always ends its request.
  a_inc_last: assert property (@(posedge clk) disable iff (rst)
    done && result.status |-> result.last && result.vertex_x == 0)
    else $error("incomplete result not final or not zero");

  // A ring request keeps the block busy on the next cycle.
  a_ring_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.mode == MODE_RING |=> busy)
    else $error("ring request did not raise busy");

  // A load completes at once.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.mode == MODE_LOAD |=> !busy)
    else $error("load request raised busy");

  // More results follow a result that is not the last one.
  a_more: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> busy)
    else $error("block idle before the last result");

endmodule

bind ellipsoid_ring_vertex_generator_core ervg_checker u_ervg_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
`default_nettype wire

/* bench/tb_ellipsoid_ring_vertex_generator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ellipsoid_ring_vertex_generator_core
// Self-checking bench for the ellipsoid ring vertex generator. Load and ring
// requests are driven from a queue with random gaps; each ring request is
// predicted in full and every result strobe is compared field by field.
// ----------------------------------------------------------------------------
module tb_ellipsoid_ring_vertex_generator_core;
  import ervg_pkg::*;

  localparam int LATITUDES  = 8;
  localparam int LONGITUDES = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  // Quarter-wave sine table in unsigned Q1.16, used to build the full turn.
  localparam int unsigned QUARTER_SINE [17] = '{
    0, 6424, 12785, 19024, 25080, 30893, 36410, 41576, 46341,
    50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536
  };

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  res_t result;

  ellipsoid_ring_vertex_generator_core #(
    .LATITUDES(LATITUDES),
    .LONGITUDES(LONGITUDES)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Shadow copy of the block's control points and loaded mask.
  logic signed [31:0] shadow_x [4];
  logic signed [31:0] shadow_y [4];
  logic signed [31:0] shadow_z [4];
  logic [3:0]         shadow_mask;

  req_t pending_requests [$];
  res_t expected_vertices [$];

  int mismatches;
  int vertices_seen;
  int rings_done;
  int loads_done;
  int idle_cycles;
  int gap_left;
  bit stimulus_done;

  // Signed sine in Q1.16 for a phase in 1/64 turn.
  function automatic longint signed trig_of(input int unsigned phase);
    int unsigned quadrant;
    int unsigned offset;
    longint signed mag;
    quadrant = (phase >> 4) & 3;
    offset   = phase & 15;
    mag = (quadrant & 1) ? QUARTER_SINE[16 - offset] : QUARTER_SINE[offset];
    return (quadrant & 2) ? -mag : mag;
  endfunction

  // Floor square root of a 66-bit sum, one result bit per pass.
  function automatic logic [33:0] isqrt66(input logic [65:0] value);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    rem  = '0;
    root = '0;
    // The top pass covers bits 65:64, the rest pairs below.
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | 68'(value[2*i +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [33:0] axis_radius(input int slot);
    logic [32:0] dx, dy, dz;
    logic [65:0] sum;
    longint signed d;
    d  = longint'(shadow_x[slot]) - longint'(shadow_x[0]);
    dx = 33'(d < 0 ? -d : d);
    d  = longint'(shadow_y[slot]) - longint'(shadow_y[0]);
    dy = 33'(d < 0 ? -d : d);
    d  = longint'(shadow_z[slot]) - longint'(shadow_z[0]);
    dz = 33'(d < 0 ? -d : d);
    sum = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
    return isqrt66(sum);
  endfunction

  // Rounded magnitude product: (m * t + half) >> 16.
  function automatic logic [50:0] scale_by(input logic [50:0] m,
                                           input longint unsigned t);
    logic [70:0] prod;
    prod = 71'(m) * 71'(t) + 71'd32768;
    return 51'(prod >> 16);
  endfunction

  // Centre plus radius times one or two trig factors, saturated to 32 bits.
  function automatic logic signed [31:0] offset_coord(
      input logic signed [31:0] centre, input logic [33:0] radius,
      input longint signed f1, input longint signed f2, input bit two);
    bit negative;
    logic [50:0] m;
    longint signed total;
    negative = (f1 < 0) != (two && f2 < 0);
    m = scale_by(51'(radius), longint'(f1 < 0 ? -f1 : f1));
    if (two && (f2 < 0 ? -f2 : f2) != 65536) begin
      m = scale_by(m, longint'(f2 < 0 ? -f2 : f2));
    end
    total = longint'(centre) + (negative ? -longint'(m) : longint'(m));
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return 32'(total);
  endfunction

  // Updates the shadow state and queues the vertices a request produces.
  task automatic predict_ring(input req_t req);
    logic [33:0] ra, rb, rc;
    int unsigned lat, phi, th;
    longint signed sphi, cphi, sth, cth;
    res_t v;
    if (req.mode == MODE_LOAD) begin
      shadow_x[req.point_slot] = req.point_x;
      shadow_y[req.point_slot] = req.point_y;
      shadow_z[req.point_slot] = req.point_z;
      shadow_mask[req.point_slot] = 1'b1;
      return;
    end
    if (shadow_mask != 4'hF) begin
      v = '0;
      v.last = 1'b1;
      v.status = 1'b1;
      expected_vertices = {expected_vertices, v};
      return;
    end
    ra = axis_radius(1);
    rb = axis_radius(2);
    rc = axis_radius(3);
    // Rings beyond the north pole are clamped onto it.
    lat  = (req.ring > LATITUDES) ? LATITUDES : req.ring;
    phi  = ((lat * 32 + LATITUDES / 2) / LATITUDES + 48) & 63;
    sphi = trig_of(phi);
    cphi = trig_of((phi + 16) & 63);
    for (int col = 0; col < LONGITUDES; col++) begin
      th  = ((col * 64 + LONGITUDES / 2) / LONGITUDES) & 63;
      sth = trig_of(th);
      cth = trig_of((th + 16) & 63);
      v.vertex_x = offset_coord(shadow_x[0], ra, cphi, cth, 1'b1);
      v.vertex_y = offset_coord(shadow_y[0], rb, cphi, sth, 1'b1);
      v.vertex_z = offset_coord(shadow_z[0], rc, sphi, 0, 1'b0);
      v.column   = 4'(col);
      v.last     = (col == LONGITUDES - 1);
      v.status   = 1'b0;
      expected_vertices = {expected_vertices, v};
    end
  endtask

  function automatic req_t load_req(input logic [1:0] slot, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] z);
    req_t r;
    r.mode = MODE_LOAD;
    r.point_slot = slot;
    r.point_x = x;
    r.point_y = y;
    r.point_z = z;
    r.ring = 4'($urandom);
    return r;
  endfunction

  function automatic req_t ring_req(input logic [3:0] ring);
    req_t r;
    r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
    r.mode = MODE_RING;
    r.ring = ring;
    return r;
  endfunction

  // Coordinates mostly small, sometimes at the extremes of Q16.16.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  // Driver: one request in flight on start, a random gap before each.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= $urandom_range(0, 12);
    end else if (start && !busy) begin
      predict_ring(request);
      if (request.mode == MODE_LOAD) loads_done <= loads_done + 1;
      else rings_done <= rings_done + 1;
      void'(pending_requests.pop_front());
      start <= 1'b0;
      gap_left <= $urandom_range(0, 12);
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() > 0) begin
        start   <= 1'b1;
        request <= pending_requests[0];
      end
    end
  end

  // Monitor: every strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    res_t exp_v;
    if (!rst && done) begin
      vertices_seen <= vertices_seen + 1;
      if (expected_vertices.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", result);
      end else begin
        exp_v = expected_vertices.pop_front();
        if (result !== exp_v) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result differs: expected %p, got %p", exp_v, result);
        end
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Run stalled after %0d point loads and %0d ring requests, %0d results checked.",
                 loads_done, rings_done, vertices_seen);
        $display("ellipsoid_ring_vertex_generator_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] cx, cy, cz;
    start = 1'b0;
    request = '0;
    rst = 1'b1;
    mismatches = 0;
    vertices_seen = 0;
    rings_done = 0;
    loads_done = 0;
    idle_cycles = 0;
    stimulus_done = 1'b0;
    shadow_mask = '0;
    for (int s = 0; s < 4; s++) begin
      shadow_x[s] = '0;
      shadow_y[s] = '0;
      shadow_z[s] = '0;
    end

    // Directed part: incomplete requests, a spread of rings including those past the
    // pole, extreme coordinates that saturate, and slots written twice.
    pending_requests = {pending_requests, ring_req(4'd3)};
    pending_requests = {pending_requests, load_req(2'd0, 32'd0, 32'd0, 32'd0)};
    pending_requests = {pending_requests, ring_req(4'd0)};
    pending_requests = {pending_requests, load_req(2'd1, 32'h0001_0000, 32'd0, 32'd0)};
    pending_requests = {pending_requests, load_req(2'd2, 32'd0, 32'h0002_0000, 32'd0)};
    pending_requests = {pending_requests, ring_req(4'd8)};
    pending_requests = {pending_requests, load_req(2'd3, 32'd0, 32'd0, 32'h0003_0000)};
    for (int r = 0; r < 16; r += 3) pending_requests = {pending_requests, ring_req(4'(r))};
    pending_requests = {pending_requests, ring_req(4'd15)};
    pending_requests = {pending_requests,
                        load_req(2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF)};
    pending_requests = {pending_requests,
                        load_req(2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000)};
    pending_requests = {pending_requests,
                        load_req(2'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000)};
    pending_requests = {pending_requests,
                        load_req(2'd3, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF)};
    pending_requests = {pending_requests, ring_req(4'd4)};
    pending_requests = {pending_requests, ring_req(4'd8)};
    pending_requests = {pending_requests, ring_req(4'd0)};

    // Random part: single point loads, full point sets near a centre, and rings.
    for (int n = 0; n < 230; ) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_requests = {pending_requests, load_req(2'($urandom), rand_coord(),
                                                       rand_coord(), rand_coord())};
        n++;
      end else if ($urandom_range(0, 2) == 0) begin
        cx = rand_coord();
        cy = rand_coord();
        cz = rand_coord();
        pending_requests = {pending_requests, load_req(2'd0, cx, cy, cz)};
        for (int s = 1; s < 4; s++)
          pending_requests = {pending_requests,
                              load_req(2'(s), cx + 32'($signed($urandom_range(0, 32'h3FFFFF))
                                       - 32'sh200000), cy + 32'($urandom_range(0, 32'h1FFFFF)),
                                       rand_coord())};
        n += 4;
      end else begin
        pending_requests = {pending_requests, ring_req(4'($urandom_range(0, 15)))};
        n++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending_requests.size() == 0 && !start);
    wait (expected_vertices.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d point loads and %0d ring requests, %0d results checked.",
             loads_done, rings_done, vertices_seen);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("ellipsoid_ring_vertex_generator_core: match");
    end else begin
      $display("ellipsoid_ring_vertex_generator_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/ervg_pkg.sv
rtl/core/ervg_dp.sv
rtl/core/ervg_ctrl.sv
rtl/core/ellipsoid_ring_vertex_generator_core.sv
rtl/core/ervg_checker.sv
bench/tb_ellipsoid_ring_vertex_generator_core.sv
